[hw/rtl/dtse_pkg.sv]
// shared types and constants for the date and time set editor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dtse_pkg;

  localparam int BLINK_TICKS_DEF = 500;

  typedef enum logic [2:0] {
    OP_MODE  = 3'd0,
    OP_NEXT  = 3'd1,
    OP_INC   = 3'd2,
    OP_DEC   = 3'd3,
    OP_LOAD  = 3'd4,
    OP_TICK  = 3'd5
  } op_t;

  localparam logic [2:0] FIELD_YEAR   = 3'd0;
  localparam logic [2:0] FIELD_MONTH  = 3'd1;
  localparam logic [2:0] FIELD_DAY    = 3'd2;
  localparam logic [2:0] FIELD_HOUR   = 3'd3;
  localparam logic [2:0] FIELD_MINUTE = 3'd4;
  localparam logic [2:0] FIELD_SECOND = 3'd5;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } date_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [6:0] year_in;
    logic [3:0] month_in;
    logic [4:0] day_in;
    logic [4:0] hour_in;
    logic [5:0] minute_in;
    logic [5:0] second_in;
  } item_t;

  typedef struct packed {
    logic [6:0] year_out;
    logic [3:0] month_out;
    logic [4:0] day_out;
    logic [4:0] hour_out;
    logic [5:0] minute_out;
    logic [5:0] second_out;
    logic [2:0] field_selected;
    logic       in_set_mode;
    logic       blank_field;
    logic       commit_pulse;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/dtse_edit.sv]
// step of the selected date/time field up or down, with range repair (up: values above range; down: month and day)
// depends on dtse_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtse_edit import dtse_pkg::*; (
  input  date_t      cur,
  input  logic [2:0] sel,
  input  logic       up,
  output date_t      nxt
);

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] y);
    logic [4:0] len;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      default:                                     len = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
    endcase
    return len;
  endfunction

  logic s_y, s_m, s_d, s_h, s_mi, s_s;
  logic [7:0] y1;
  logic [4:0] m1;
  logic [5:0] d1;
  logic [5:0] h1;
  logic [6:0] mi1;
  logic [6:0] s1;
  date_t      up_v;
  date_t      dn_v;
  logic [4:0] len_up;
  logic [4:0] len_dn;
  logic [4:0] d_dec;
  logic       d_low;

  always_comb begin
    s_m  = (sel == FIELD_MONTH);
    s_d  = (sel == FIELD_DAY);
    s_h  = (sel == FIELD_HOUR);
    s_mi = (sel == FIELD_MINUTE);
    s_s  = (sel == FIELD_SECOND);
    s_y  = !(s_m || s_d || s_h || s_mi || s_s);

    // increment path
    y1  = {1'b0, cur.year}   + {7'd0, s_y};
    m1  = {1'b0, cur.month}  + {4'd0, s_m};
    d1  = {1'b0, cur.day}    + {5'd0, s_d};
    h1  = {1'b0, cur.hour}   + {5'd0, s_h};
    mi1 = {1'b0, cur.minute} + {6'd0, s_mi};
    s1  = {1'b0, cur.second} + {6'd0, s_s};
    up_v.year   = (y1 > 8'd99) ? 7'd0 : y1[6:0];
    up_v.month  = (m1 > 5'd12) ? 4'd1 : m1[3:0];
    len_up      = month_len(up_v.month, up_v.year);
    up_v.day    = (d1 > {1'b0, len_up}) ? 5'd1 : d1[4:0];
    up_v.hour   = (h1 > 6'd23) ? 5'd0 : h1[4:0];
    up_v.minute = (mi1 > 7'd59) ? 6'd0 : mi1[5:0];
    up_v.second = (s1 > 7'd59) ? 6'd0 : s1[5:0];

    // decrement path
    if (s_y) begin
      dn_v.year = (cur.year == 7'd0) ? 7'd99 : cur.year - 7'd1;
    end else begin
      dn_v.year = cur.year;
    end
    if (s_m) begin
      dn_v.month = (cur.month <= 4'd1) ? 4'd12 : cur.month - 4'd1;
    end else begin
      dn_v.month = (cur.month == 4'd0) ? 4'd12 : cur.month;
    end
    len_dn = month_len(dn_v.month, dn_v.year);
    d_low  = s_d ? (cur.day <= 5'd1) : (cur.day == 5'd0);
    d_dec  = s_d ? cur.day - 5'd1 : cur.day;
    if (d_low) begin
      dn_v.day = len_dn;
    end else if (d_dec > len_dn) begin
      dn_v.day = 5'd1;
    end else begin
      dn_v.day = d_dec;
    end
    if (s_h) begin
      dn_v.hour = (cur.hour == 5'd0) ? 5'd23 : cur.hour - 5'd1;
    end else begin
      dn_v.hour = cur.hour;
    end
    if (s_mi) begin
      dn_v.minute = (cur.minute == 6'd0) ? 6'd59 : cur.minute - 6'd1;
    end else begin
      dn_v.minute = cur.minute;
    end
    if (s_s) begin
      dn_v.second = (cur.second == 6'd0) ? 6'd59 : cur.second - 6'd1;
    end else begin
      dn_v.second = cur.second;
    end

    nxt = up ? up_v : dn_v;
  end

endmodule

`default_nettype wire

[hw/rtl/dtse_core.sv]
// editor state: mode, field selection, blink counter and date/time registers
// depends on dtse_pkg and dtse_edit
`timescale 1ns / 1ps
`default_nettype none

module dtse_core import dtse_pkg::*; #(
  parameter int BLINK_TICKS = BLINK_TICKS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  item_t   item,
  output result_t res
);

  localparam int TickW = $clog2(BLINK_TICKS);

  logic             set_mode, set_mode_next;
  logic [2:0]       field_index, field_index_next;
  logic             blink_flag, blink_flag_next;
  logic [TickW-1:0] tick_count, tick_count_next;
  date_t            date, date_next;
  date_t            edited;
  logic             commit;
  logic [TickW:0]   tick_inc;

  dtse_edit u_edit (
    .cur (date),
    .sel (field_index),
    .up  (item.operation == OP_INC),
    .nxt (edited)
  );

  always_comb begin
    set_mode_next    = set_mode;
    field_index_next = field_index;
    blink_flag_next  = blink_flag;
    tick_count_next  = tick_count;
    date_next        = date;
    commit           = 1'b0;
    tick_inc         = {1'b0, tick_count} + {{TickW{1'b0}}, 1'b1};
    unique case (op_t'(item.operation)) inside
      OP_MODE: begin
        set_mode_next = !set_mode;
        commit        = set_mode;
      end
      OP_NEXT: begin
        if (set_mode) begin
          field_index_next = (field_index >= FIELD_SECOND) ? FIELD_YEAR
                                                          : field_index + 3'd1;
        end
      end
      OP_INC, OP_DEC: begin
        if (set_mode) begin
          date_next = edited;
        end
      end
      OP_LOAD: begin
        if (!set_mode) begin
          date_next.year   = item.year_in;
          date_next.month  = item.month_in;
          date_next.day    = item.day_in;
          date_next.hour   = item.hour_in;
          date_next.minute = item.minute_in;
          date_next.second = item.second_in;
        end
      end
      OP_TICK: begin
        if (tick_inc >= (TickW+1)'(BLINK_TICKS)) begin
          tick_count_next = '0;
          blink_flag_next = !blink_flag;
        end else begin
          tick_count_next = tick_inc[TickW-1:0];
        end
      end
      default: begin
      end
    endcase

    res.year_out       = date_next.year;
    res.month_out      = date_next.month;
    res.day_out        = date_next.day;
    res.hour_out       = date_next.hour;
    res.minute_out     = date_next.minute;
    res.second_out     = date_next.second;
    res.field_selected = field_index_next;
    res.in_set_mode    = set_mode_next;
    res.blank_field    = set_mode_next & blink_flag_next;
    res.commit_pulse   = commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_mode    <= 1'b0;
      field_index <= FIELD_YEAR;
      blink_flag  <= 1'b0;
      tick_count  <= '0;
      date        <= '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0,
                       minute: 6'd0, second: 6'd0};
    end else if (en) begin
      set_mode    <= set_mode_next;
      field_index <= field_index_next;
      blink_flag  <= blink_flag_next;
      tick_count  <= tick_count_next;
      date        <= date_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/date_time_set_editor_top.sv]
// date and time set editor: input register, update logic, result register
// path: an item is held in the input register, then its result in the result register
// throughput: one item per cycle unless result_ready stalls the result register; dtse_core updates its state per item
// reset: synchronous rst clears both pipeline valids and all editor state
// depends on dtse_pkg and dtse_core
`timescale 1ns / 1ps
`default_nettype none

module date_time_set_editor_top import dtse_pkg::*; #(
  parameter int BLINK_TICKS = BLINK_TICKS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic    stage_valid;
  item_t   stage;
  logic    advance;
  result_t res;

  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  dtse_core #(.BLINK_TICKS(BLINK_TICKS)) u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (stage),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        stage_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage <= item;
    end
    if (advance) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

[bench/tb.sv]
// self-checking testbench for date_time_set_editor_top: directed and random key sequences
// a predictor of the editor state checks every display transfer, with random gaps and stalls
// depends on dtse_pkg and date_time_set_editor_top
`timescale 1ns / 1ps

module tb;
  import dtse_pkg::*;

  localparam int BLINK = BLINK_TICKS_DEF;
  localparam int LATENCY = 2;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  always #5 clk = ~clk;

  date_time_set_editor_top #(
    .BLINK_TICKS(BLINK)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  // predicted editor state
  logic       mode_q = 1'b0;
  logic [2:0] field_q = FIELD_YEAR;
  logic       blink_q = 1'b0;
  int         tick_q = 0;
  date_t      now_q = '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0,
                        second: 6'd0};

  result_t pending_displays[$];
  int      errors = 0;
  int      sent = 0;
  int      checked = 0;
  int      commits = 0;
  int      blanks = 0;
  int      toggles = 0;
  bit      quiet = 1'b0;

  function automatic int days_in_month(int month, int year);
    case (month)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      default:               return (year % 4 == 0) ? 29 : 28;
    endcase
  endfunction

  task automatic step_field(input bit up);
    int v[6];
    int len;
    v[0] = now_q.year;
    v[1] = now_q.month;
    v[2] = now_q.day;
    v[3] = now_q.hour;
    v[4] = now_q.minute;
    v[5] = now_q.second;
    v[int'(field_q)] += up ? 1 : -1;
    if (up) begin
      if (v[0] > 99) v[0] = 0;
      if (v[1] > 12) v[1] = 1;
      len = days_in_month(v[1], v[0]);
      if (v[2] > len) v[2] = 1;
      if (v[3] > 23) v[3] = 0;
      if (v[4] > 59) v[4] = 0;
      if (v[5] > 59) v[5] = 0;
    end else begin
      if (v[0] < 0) v[0] = 99;
      if (v[1] < 1) v[1] = 12;
      len = days_in_month(v[1], v[0]);
      if (v[2] < 1) v[2] = len;
      else if (v[2] > len) v[2] = 1;
      if (v[3] < 0) v[3] = 23;
      if (v[4] < 0) v[4] = 59;
      if (v[5] < 0) v[5] = 59;
    end
    now_q.year   = 7'(v[0]);
    now_q.month  = 4'(v[1]);
    now_q.day    = 5'(v[2]);
    now_q.hour   = 5'(v[3]);
    now_q.minute = 6'(v[4]);
    now_q.second = 6'(v[5]);
  endtask

  task automatic advance_editor(input item_t it, output result_t shown);
    bit commit;
    commit = 1'b0;
    case (it.operation)
      OP_MODE: begin
        if (mode_q) begin
          commit = 1'b1;
          mode_q = 1'b0;
        end else begin
          mode_q = 1'b1;
        end
      end
      OP_NEXT: begin
        if (mode_q) field_q = (field_q >= FIELD_SECOND) ? FIELD_YEAR : field_q + 3'd1;
      end
      OP_INC: begin
        if (mode_q) step_field(1'b1);
      end
      OP_DEC: begin
        if (mode_q) step_field(1'b0);
      end
      OP_LOAD: begin
        if (!mode_q) now_q = {it.year_in, it.month_in, it.day_in, it.hour_in, it.minute_in,
                              it.second_in};
      end
      OP_TICK: begin
        tick_q = (tick_q + 1) % 512;
        if (tick_q >= BLINK) begin
          tick_q = 0;
          blink_q = ~blink_q;
          toggles++;
        end
      end
      default: ;
    endcase
    shown.year_out       = now_q.year;
    shown.month_out      = now_q.month;
    shown.day_out        = now_q.day;
    shown.hour_out       = now_q.hour;
    shown.minute_out     = now_q.minute;
    shown.second_out     = now_q.second;
    shown.field_selected = field_q;
    shown.in_set_mode    = mode_q;
    shown.blank_field    = mode_q & blink_q;
    shown.commit_pulse   = commit;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t key_item(input logic [2:0] op);
    item_t it;
    it = item_t'({$urandom, $urandom});
    it.operation = op;
    return it;
  endfunction

  function automatic item_t load_item(input bit wild);
    item_t it;
    it = key_item(OP_LOAD);
    if (!wild) begin
      it.year_in   = 7'($urandom_range(0, 99));
      it.month_in  = 4'($urandom_range(1, 12));
      it.day_in    = 5'($urandom_range(1, 31));
      it.hour_in   = 5'($urandom_range(0, 23));
      it.minute_in = 6'($urandom_range(0, 59));
      it.second_in = 6'($urandom_range(0, 59));
    end
    return it;
  endfunction

  function automatic item_t load_of(input int y, input int mo, input int d, input int h,
                                    input int mi, input int s);
    item_t it;
    it = key_item(OP_LOAD);
    it.year_in   = 7'(y);
    it.month_in  = 4'(mo);
    it.day_in    = 5'(d);
    it.hour_in   = 5'(h);
    it.minute_in = 6'(mi);
    it.second_in = 6'(s);
    return it;
  endfunction

  function automatic item_t edit_key(input int tick_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < tick_pct) return key_item(OP_TICK);
    r = $urandom_range(0, 19);
    if (r < 5) return key_item(OP_NEXT);
    if (r < 11) return key_item(OP_INC);
    if (r < 17) return key_item(OP_DEC);
    if (r < 18) return load_item(1'b1);
    return key_item(r == 18 ? OP_SPARE_A : OP_SPARE_B);
  endfunction

  // called right after a rising edge; returns right after the transfer edge
  task automatic transfer_item(input item_t it);
    int gap;
    result_t shown;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    advance_editor(it, shown);
    pending_displays.push_back(shown);
    sent++;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_displays.size() == 0) begin
        $error("display transfer with no item pending: %h", result);
        errors++;
      end else begin
        want = pending_displays.pop_front();
        checked++;
        check_field("year_out", want.year_out, result.year_out);
        check_field("month_out", want.month_out, result.month_out);
        check_field("day_out", want.day_out, result.day_out);
        check_field("hour_out", want.hour_out, result.hour_out);
        check_field("minute_out", want.minute_out, result.minute_out);
        check_field("second_out", want.second_out, result.second_out);
        check_field("field_selected", want.field_selected, result.field_selected);
        check_field("in_set_mode", want.in_set_mode, result.in_set_mode);
        check_field("blank_field", want.blank_field, result.blank_field);
        check_field("commit_pulse", want.commit_pulse, result.commit_pulse);
        if (result.commit_pulse) commits++;
        if (result.blank_field) blanks++;
      end
    end
  end

  // display side stalls
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        n = pick_gap();
        if (n > 0) begin
          result_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      result_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic test_idle_keys();
    transfer_item(key_item(OP_SPARE_A));
    transfer_item(key_item(OP_SPARE_B));
    transfer_item(key_item(OP_NEXT));
    transfer_item(key_item(OP_INC));
    transfer_item(key_item(OP_DEC));
  endtask

  task automatic test_load_extremes();
    transfer_item(load_of(127, 15, 31, 31, 63, 63));
    transfer_item(load_of(0, 0, 0, 0, 0, 0));
    transfer_item(load_of(99, 12, 31, 23, 59, 59));
  endtask

  task automatic test_edit_wrap();
    transfer_item(key_item(OP_MODE));
    transfer_item(load_of(0, 0, 0, 0, 0, 0));
    transfer_item(key_item(OP_INC));
    transfer_item(key_item(OP_DEC));
    transfer_item(key_item(OP_NEXT));
    transfer_item(key_item(OP_INC));
    transfer_item(key_item(OP_NEXT));
    transfer_item(key_item(OP_INC));
    transfer_item(key_item(OP_DEC));
    transfer_item(key_item(OP_NEXT));
    transfer_item(key_item(OP_INC));
    transfer_item(key_item(OP_NEXT));
    transfer_item(key_item(OP_DEC));
    transfer_item(key_item(OP_NEXT));
    transfer_item(key_item(OP_INC));
    // leave and re-enter: selection stays on seconds
    transfer_item(key_item(OP_MODE));
    transfer_item(key_item(OP_MODE));
    transfer_item(key_item(OP_NEXT));
    transfer_item(key_item(OP_MODE));
  endtask

  task automatic edit_session();
    int n;
    if (mode_q && $urandom_range(0, 1) == 0) transfer_item(key_item(OP_MODE));
    repeat ($urandom_range(0, 4)) transfer_item(edit_key(70));
    if ($urandom_range(0, 3) != 0) transfer_item(load_item($urandom_range(0, 3) == 0));
    transfer_item(key_item(OP_MODE));
    n = $urandom_range(2, 18);
    repeat (n) transfer_item(edit_key(60));
    // now and then the session is left open
    if ($urandom_range(0, 19) != 0) transfer_item(key_item(OP_MODE));
  endtask

  task automatic test_back_to_back(input int count);
    int stop;
    stop = sent + count;
    quiet = 1'b1;
    while (sent < stop) edit_session();
    quiet = 1'b0;
  endtask

  task automatic test_random_sessions(input int count);
    int stop;
    stop = sent + count;
    while (sent < stop) edit_session();
  endtask

  task automatic test_blink();
    if (!mode_q) transfer_item(key_item(OP_MODE));
    while (!blink_q) transfer_item(edit_key(85));
    repeat (60) transfer_item(edit_key(50));
    transfer_item(key_item(OP_MODE));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_idle_keys();
    test_load_extremes();
    test_edit_wrap();
    test_back_to_back(100);
    test_random_sessions(550);
    test_blink();
    item_valid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (4 * LATENCY + 4) @(posedge clk);
    $display("%0d key transfers sent, %0d displays checked, %0d commits", sent, checked,
             commits);
    $display("blink toggled %0d times, %0d displays with the field blanked", toggles, blanks);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
